// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, codes and controller/datapath interface types for the
// first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Slot table geometry
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = SLOT_W + 1;

    // Field widths
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 25;
    localparam int STAT_W = 3;
    localparam int END_W  = ADDR_W + 1;   // end address may reach 2^32
    localparam int STOP_W = ADDR_W + 2;   // candidate end before range check

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_BYTES = 1'b1;
    localparam logic [SIZE_W-1:0] HEAP_BYTES_RST = SIZE_W'(1048576);

    // Heap end saturates at 2^32
    localparam logic [END_W-1:0] HEAP_LIMIT = {1'b1, {ADDR_W{1'b0}}};

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOMEM    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FIND,
        S_CAND_BASE,
        S_TEST,
        S_INNER,
        S_TAIL,
        S_NEXT,
        S_CLOAD,
        S_COMMIT,
        S_FREE,
        S_FREE_TAIL,
        S_FREE_FIN,
        S_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              load_req;    // capture request, clear scan
        logic              scan_clr;
        logic              scan_inc;
        logic              scan_issue;  // read table at scan index
        logic              slot_cap;    // record free slot at scan index
        logic              cand_base;   // candidate = heap base
        logic              cand_inc;
        logic              cand_rd;     // read table at candidate index
        logic              cand_load;   // candidate = end of read slot
        logic              commit;      // write new slot
        logic              free_proc;   // release matching slot
        logic              out_load;
        logic [STAT_W-1:0] status;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic op_free;
        logic size_zero;
        logic size_big;
        logic scan_last;
        logic scan_end;
        logic scan_used;
        logic cand_end;
        logic cand_used;
        logic range_ok;
        logic overlap;
        logic found;
        logic out_busy;
    } stat_t;

endpackage

// ===== rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over a 64-entry slot table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel (valid/ready): s_op selects allocate or
//   free, s_req_size gives the allocate size, s_free_addr the region to free.
//   One result per request leaves on the m_ channel: m_status, m_grant_addr
//   and m_free_bytes. heap_base and heap_bytes are set over the APB port
//   (offsets 0x0 and 0x4); the user must write them only while no request
//   is in flight, as the block does not enforce this. One request is
//   processed at a time. An allocate of zero size or of more bytes than
//   are free is rejected without a table scan. A free reads the table once
//   per slot. An allocate searches for a free slot, then runs an overlap
//   scan of the table for each tried candidate, up to SLOT_COUNT candidates
//   (heap base plus the ends of at most SLOT_COUNT - 1 used slots).
//   The slot table has a single read port and is read one slot per cycle.
//   Reset empties the table (all used bits cleared), zeroes the allocated
//   count and sets heap_base to 0 and heap_bytes to 1 MiB.
//   A result waits in the output register while m_ready is low; the request
//   after it is accepted but its result holds until the register frees.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [ffba_pkg::SIZE_W-1:0]   s_req_size,
    input  logic [ffba_pkg::ADDR_W-1:0]   s_free_addr,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ffba_pkg::STAT_W-1:0]   m_status,
    output logic [ffba_pkg::ADDR_W-1:0]   m_grant_addr,
    output logic [ffba_pkg::SIZE_W-1:0]   m_free_bytes,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffba_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffba_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ffba_pkg::*;

    logic [ADDR_W-1:0] heap_base;
    logic [SIZE_W-1:0] heap_bytes;
    cmd_t              cmd;
    stat_t             stat;

    // Configuration registers
    ffba_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .heap_base  (heap_base),
        .heap_bytes (heap_bytes)
    );

    // Request sequencer
    ffba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Slot table and arithmetic
    ffba_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_op         (s_op),
        .s_req_size   (s_req_size),
        .s_free_addr  (s_free_addr),
        .heap_base    (heap_base),
        .heap_bytes   (heap_bytes),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_status     (m_status),
        .m_grant_addr (m_grant_addr),
        .m_free_bytes (m_free_bytes)
    );

    // A failed or free request never carries a grant address
    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_grant_addr == '0)
        else $error("grant address set on a failed request");

    // One request at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in progress");

    // Reported free bytes never exceed the heap size
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_free_bytes <= heap_bytes)
        else $error("free byte count above heap size");

endmodule

// ===== rtl/ffba_regs.sv =====
// ----------------------------------------------------------------------------
// ffba_regs
// APB-style configuration registers: heap base and heap size.
// ----------------------------------------------------------------------------
module ffba_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffba_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffba_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [ffba_pkg::ADDR_W-1:0]   heap_base,
    output logic [ffba_pkg::SIZE_W-1:0]   heap_bytes
);
    import ffba_pkg::*;

    logic [ADDR_W-1:0] heap_base_reg;
    logic [SIZE_W-1:0] heap_bytes_reg;
    logic              reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= '0;
            heap_bytes_reg <= HEAP_BYTES_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEAP_BASE:  heap_base_reg  <= pwdata[ADDR_W-1:0];
                REG_HEAP_BYTES: heap_bytes_reg <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_HEAP_BASE:  prdata = heap_base_reg;
            REG_HEAP_BYTES: prdata = {{(PDATA_W-SIZE_W){1'b0}}, heap_bytes_reg};
            default:        prdata = '0;
        endcase
    end

    assign heap_base  = heap_base_reg;
    assign heap_bytes = heap_bytes_reg;

endmodule

// ===== rtl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for allocate and free requests: free-slot search, candidate
// walk, overlap scan, release scan and result hand-off.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ffba_pkg::stat_t stat,
    output ffba_pkg::cmd_t  cmd
);
    import ffba_pkg::*;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // Next state and result code
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (stat.op_free) begin
                    state_next = S_FREE;
                end else if (stat.size_zero) begin
                    state_next  = S_DONE;
                    status_next = ST_ZERO;
                end else if (stat.size_big) begin
                    state_next  = S_DONE;
                    status_next = ST_NOMEM;
                end else begin
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                if (stat.scan_end) begin
                    state_next  = S_DONE;
                    status_next = ST_NOFIT;
                end else if (!stat.scan_used) begin
                    state_next = S_CAND_BASE;
                end
            end
            S_CAND_BASE: state_next = S_TEST;
            S_TEST: begin
                state_next = stat.range_ok ? S_INNER : S_NEXT;
            end
            S_INNER: begin
                if (stat.overlap)        state_next = S_NEXT;
                else if (stat.scan_last) state_next = S_TAIL;
            end
            S_TAIL: begin
                state_next = stat.overlap ? S_NEXT : S_COMMIT;
            end
            S_NEXT: begin
                if (stat.cand_end) begin
                    state_next  = S_DONE;
                    status_next = ST_NOFIT;
                end else if (stat.cand_used) begin
                    state_next = S_CLOAD;
                end
            end
            S_CLOAD: state_next = S_TEST;
            S_COMMIT: begin
                state_next  = S_DONE;
                status_next = ST_OK;
            end
            S_FREE: begin
                if (stat.scan_last) state_next = S_FREE_TAIL;
            end
            S_FREE_TAIL: state_next = S_FREE_FIN;
            S_FREE_FIN: begin
                state_next  = S_DONE;
                status_next = stat.found ? ST_OK : ST_NOTFOUND;
            end
            S_DONE: begin
                if (!stat.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd        = '0;
        cmd.status = status_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            S_FIND: begin
                if (!stat.scan_end) begin
                    if (stat.scan_used) cmd.scan_inc = 1'b1;
                    else                cmd.slot_cap = 1'b1;
                end
            end
            S_CAND_BASE: cmd.cand_base = 1'b1;
            S_TEST:      cmd.scan_clr  = 1'b1;
            S_INNER: begin
                cmd.scan_issue = 1'b1;
                cmd.scan_inc   = 1'b1;
            end
            S_NEXT: begin
                if (!stat.cand_end) begin
                    cmd.cand_rd  = 1'b1;
                    cmd.cand_inc = 1'b1;
                end
            end
            S_CLOAD:  cmd.cand_load = 1'b1;
            S_COMMIT: cmd.commit    = 1'b1;
            S_FREE: begin
                cmd.scan_issue = 1'b1;
                cmd.scan_inc   = 1'b1;
                cmd.free_proc  = 1'b1;
            end
            S_FREE_TAIL: cmd.free_proc = 1'b1;
            S_DONE:      cmd.out_load  = !stat.out_busy;
            default: ;
        endcase
    end

endmodule

// ===== rtl/ffba_dp.sv =====
// ----------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: slot table memories, used bits, scan counters,
// candidate and overlap compares, byte accounting and result register.
// ----------------------------------------------------------------------------
module ffba_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ffba_pkg::cmd_t               cmd,
    output ffba_pkg::stat_t              stat,
    input  logic                         s_op,
    input  logic [ffba_pkg::SIZE_W-1:0]  s_req_size,
    input  logic [ffba_pkg::ADDR_W-1:0]  s_free_addr,
    input  logic [ffba_pkg::ADDR_W-1:0]  heap_base,
    input  logic [ffba_pkg::SIZE_W-1:0]  heap_bytes,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [ffba_pkg::STAT_W-1:0]  m_status,
    output logic [ffba_pkg::ADDR_W-1:0]  m_grant_addr,
    output logic [ffba_pkg::SIZE_W-1:0]  m_free_bytes
);
    import ffba_pkg::*;

    // Request capture
    logic              op_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [END_W-1:0]  heap_top_reg;

    // Counters and candidate
    logic [CNT_W-1:0]  scan_reg, cand_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [END_W-1:0]  cand_addr_reg;
    logic [STOP_W-1:0] stop_reg;

    // Slot table
    logic [ADDR_W-1:0]     start_mem [SLOT_COUNT];
    logic [SIZE_W-1:0]     size_mem  [SLOT_COUNT];
    logic [END_W-1:0]      end_mem   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] used_reg;
    logic [ADDR_W-1:0]     rd_start_reg;
    logic [SIZE_W-1:0]     rd_size_reg;
    logic [END_W-1:0]      rd_end_reg;
    logic                  pv_reg;
    logic [SLOT_W-1:0]     pidx_reg;

    logic [SIZE_W-1:0] alloc_reg;
    logic              found_reg;

    // Result register
    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [ADDR_W-1:0] m_grant_reg;
    logic [SIZE_W-1:0] m_free_reg;

    logic [SLOT_W-1:0] scan_idx, cand_idx, rd_addr;
    logic [SIZE_W-1:0] free_count;
    logic [END_W-1:0]  heap_sum;
    logic              free_hit;

    assign scan_idx = scan_reg[SLOT_W-1:0];
    assign cand_idx = cand_reg[SLOT_W-1:0];
    assign rd_addr  = cmd.cand_rd ? cand_idx : scan_idx;

    assign free_count = (alloc_reg >= heap_bytes) ? '0 : heap_bytes - alloc_reg;
    assign heap_sum   = {1'b0, heap_base} + END_W'(heap_bytes);
    assign free_hit   = pv_reg && (rd_start_reg == addr_reg);

    // Status to controller
    always_comb begin
        stat           = '0;
        stat.op_free   = (op_reg == OP_FREE);
        stat.size_zero = (size_reg == '0);
        stat.size_big  = (size_reg > free_count);
        stat.scan_last = (scan_reg == CNT_W'(SLOT_COUNT - 1));
        stat.scan_end  = (scan_reg == CNT_W'(SLOT_COUNT));
        stat.scan_used = used_reg[scan_idx];
        stat.cand_end  = (cand_reg == CNT_W'(SLOT_COUNT));
        stat.cand_used = used_reg[cand_idx];
        stat.range_ok  = (cand_addr_reg >= {1'b0, heap_base})
                      && (stop_reg <= {1'b0, heap_top_reg});
        stat.overlap   = pv_reg && (cand_addr_reg < rd_end_reg)
                      && ({2'b00, rd_start_reg} < stop_reg);
        stat.found     = found_reg;
        stat.out_busy  = m_valid_reg && !m_ready;
    end

    // Request payload and heap end
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg       <= s_op;
            size_reg     <= s_req_size;
            addr_reg     <= s_free_addr;
            heap_top_reg <= (heap_sum > HEAP_LIMIT) ? HEAP_LIMIT : heap_sum;
        end
    end

    // Scan and candidate counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
            cand_reg <= '0;
            pv_reg   <= 1'b0;
        end else begin
            if (cmd.load_req || cmd.scan_clr) scan_reg <= '0;
            else if (cmd.scan_inc)             scan_reg <= scan_reg + 1'b1;
            if (cmd.cand_base)     cand_reg <= '0;
            else if (cmd.cand_inc) cand_reg <= cand_reg + 1'b1;
            pv_reg <= cmd.scan_issue && used_reg[scan_idx];
        end
    end

    // Candidate address, its end and the chosen slot
    always_ff @(posedge aclk) begin
        pidx_reg <= scan_idx;
        if (cmd.slot_cap) slot_reg <= scan_idx;
        if (cmd.cand_base) begin
            cand_addr_reg <= {1'b0, heap_base};
            stop_reg      <= {2'b00, heap_base} + STOP_W'(size_reg);
        end else if (cmd.cand_load) begin
            cand_addr_reg <= rd_end_reg;
            stop_reg      <= {1'b0, rd_end_reg} + STOP_W'(size_reg);
        end
    end

    // Slot table memories, one write and one read port
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            start_mem[slot_reg] <= cand_addr_reg[ADDR_W-1:0];
            size_mem[slot_reg]  <= size_reg;
            end_mem[slot_reg]   <= stop_reg[END_W-1:0];
        end
        rd_start_reg <= start_mem[rd_addr];
        rd_size_reg  <= size_mem[rd_addr];
        rd_end_reg   <= end_mem[rd_addr];
    end

    // Used bits and allocated byte count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            alloc_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.load_req) found_reg <= 1'b0;
            if (cmd.commit) begin
                used_reg[slot_reg] <= 1'b1;
                alloc_reg          <= alloc_reg + size_reg;
            end else if (cmd.free_proc && free_hit) begin
                used_reg[pidx_reg] <= 1'b0;
                alloc_reg <= (rd_size_reg >= alloc_reg) ? '0 : alloc_reg - rd_size_reg;
                found_reg <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= cmd.status;
            m_grant_reg  <= (cmd.status == ST_OK && op_reg == OP_ALLOC)
                          ? cand_addr_reg[ADDR_W-1:0] : '0;
            m_free_reg   <= free_count;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_grant_addr = m_grant_reg;
    assign m_free_bytes = m_free_reg;

endmodule
